@@ rtl/mms_pkg.sv @@
package mms_pkg;

	localparam int DEFAULT_MAX_DIM = 8;

	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;
	localparam int DIM_W  = 4;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SCALE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISSING  = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;

	// operand moving from cell to cell: value and the row of the held matrix it meets
	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] a;
		logic [DIM_W-1:0]        n;
	} link_t;

	typedef struct packed {
		logic clr;
		logic capture;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic                    en;
		logic [DIM_W-1:0]        row;
		logic [DIM_W-1:0]        col;
		logic signed [VAL_W-1:0] data;
	} store_wr_t;

endpackage

@@ rtl/mms_cell.sv @@
module mms_cell #(
	parameter int MAX_DIM = mms_pkg::DEFAULT_MAX_DIM,
	parameter int IDX     = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mms_pkg::cell_ctl_t               ctl,
	input  mms_pkg::store_wr_t               wr,
	input  mms_pkg::link_t                   link_in,
	output mms_pkg::link_t                   link_out,
	input  logic signed [mms_pkg::VAL_W-1:0] res_in,
	output logic signed [mms_pkg::VAL_W-1:0] res_out,
	output logic                             busy
);
	import mms_pkg::*;

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	// one column of the held matrix
	logic signed [VAL_W-1:0]  col_mem [MAX_DIM];
	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_vld_s1;
	logic                     lvld_q;
	logic signed [VAL_W-1:0]  la_q;
	logic [DIM_W-1:0]         ln_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_shr;
	logic signed [VAL_W-1:0]  sat_val;
	logic signed [VAL_W-1:0]  res_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.col == DIM_W'(IDX)) begin
			col_mem[wr.row[IDX_W-1:0]] <= wr.data;
		end
		prod_s1 <= PROD_W'($signed(link_in.a)) * PROD_W'(col_mem[link_in.n[IDX_W-1:0]]);
		la_q    <= link_in.a;
		ln_q    <= link_in.n;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (ctl.capture) begin
			res_q <= sat_val;
		end else if (ctl.shift) begin
			res_q <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			lvld_q      <= 1'b0;
		end else begin
			prod_vld_s1 <= link_in.valid;
			lvld_q      <= link_in.valid;
		end
	end

	// floor shift of the exact sum, then clamp to 32 bits
	always_comb begin
		acc_shr = acc_q >>> FRAC_W;
		if (acc_shr > SAT_HI) begin
			sat_val = SAT_HI[VAL_W-1:0];
		end else if (acc_shr < SAT_LO) begin
			sat_val = SAT_LO[VAL_W-1:0];
		end else begin
			sat_val = acc_shr[VAL_W-1:0];
		end
	end

	assign link_out = '{valid: lvld_q, a: la_q, n: ln_q};
	assign res_out  = res_q;
	assign busy     = prod_vld_s1 | lvld_q;

endmodule

@@ rtl/matrix_multiply_stream.sv @@
// Streaming Q16.16 matrix multiplier. Load the right-hand matrix with command 0, one element
// per request in row-major order; a left matrix sent with command 1 then yields one result row
// per completed left row, and command 2 returns the held matrix scaled by the request value.
// The held matrix lives in a chain of MAX_DIM cells, one column per cell, each with its own
// multiplier and wide accumulator; operands walk down the chain one cell per cycle and results
// shift back out of cell 0. The block handles one request at a time. A load request, and a left
// element that does not close a row, are taken without leaving the idle state. A left element
// that closes a row feeds the buffered row into the chain, waits for the last operand to cross
// every cell, then returns one result per column of the right matrix, each held while out_stall
// is set. A scale request does the same for each row of the held matrix in turn, feeding the
// request value once per row. An error (no complete right matrix, or mismatched dimensions)
// returns a single result with zero payload and last set; after a left-matrix error the rest
// of that matrix is dropped. No clearing pass is needed after reset.
module matrix_multiply_stream #(
	parameter int MAX_DIM = mms_pkg::DEFAULT_MAX_DIM
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mms_pkg::CMD_W-1:0]         command,
	input  logic                              first_element,
	input  logic [mms_pkg::DIM_W-1:0]         rows,
	input  logic [mms_pkg::DIM_W-1:0]         cols,
	input  logic signed [mms_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mms_pkg::VAL_W-1:0]  out_value,
	output logic [2:0]                        out_row,
	output logic [2:0]                        out_col,
	output logic [mms_pkg::DIM_W-1:0]         out_rows,
	output logic [mms_pkg::DIM_W-1:0]         out_cols,
	output logic [mms_pkg::STAT_W-1:0]        status,
	output logic                              last
);
	import mms_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FEED,
		S_WAIT,
		S_DRAIN,
		S_ERR
	} state_t;

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		return (d != '0) && (int'(d) <= MAX_DIM);
	endfunction

	state_t                  state_q;
	logic                    in_fire;
	logic                    out_fire;

	logic [DIM_W-1:0]        right_rows_q;
	logic [DIM_W-1:0]        right_cols_q;
	logic                    right_present_q;
	logic [IDX_W-1:0]        ld_r_q;
	logic [IDX_W-1:0]        ld_c_q;

	logic [DIM_W-1:0]        left_rows_q;
	logic [DIM_W-1:0]        left_cols_q;
	logic [DIM_W-1:0]        lrow_q;
	logic [IDX_W-1:0]        lpos_q;
	logic                    left_skip_q;
	logic signed [VAL_W-1:0] lbuf_q [MAX_DIM];

	logic signed [VAL_W-1:0] scale_q;
	logic                    pass_scale_q;
	logic                    final_row_q;
	logic [IDX_W-1:0]        feed_idx_q;
	logic [IDX_W-1:0]        orow_q;
	logic [IDX_W-1:0]        ocol_q;
	logic [DIM_W-1:0]        orows_q;
	logic [DIM_W-1:0]        ocols_q;
	logic [STAT_W-1:0]       status_q;
	link_t                   feed_q;

	link_t                   link [MAX_DIM+1];
	logic signed [VAL_W-1:0] res [MAX_DIM+1];
	logic [MAX_DIM-1:0]      busy;
	logic                    chain_busy;
	cell_ctl_t               ctl;
	store_wr_t               wr;

	// right-matrix load, with a first element taking effect in the same request
	logic                    dims_ok;
	logic [DIM_W-1:0]        ld_rows;
	logic [DIM_W-1:0]        ld_cols;
	logic [IDX_W-1:0]        ld_r;
	logic [IDX_W-1:0]        ld_c;
	logic                    ld_present;
	logic                    ld_write;
	logic                    ld_col_end;
	logic                    ld_last;

	// left-matrix element
	logic [DIM_W-1:0]        lf_rows;
	logic [DIM_W-1:0]        lf_cols;
	logic [DIM_W-1:0]        lf_row;
	logic [IDX_W-1:0]        lf_pos;
	logic                    lf_start_err;
	logic                    lf_active;
	logic                    lf_row_end;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = (state_q == S_DRAIN) || (state_q == S_ERR);
	assign out_fire  = out_valid && !out_stall;

	always_comb begin
		dims_ok    = dim_ok(rows) && dim_ok(cols);
		ld_rows    = first_element ? (dims_ok ? rows : '0) : right_rows_q;
		ld_cols    = first_element ? (dims_ok ? cols : '0) : right_cols_q;
		ld_r       = first_element ? '0 : ld_r_q;
		ld_c       = first_element ? '0 : ld_c_q;
		ld_present = first_element ? 1'b0 : right_present_q;
		ld_write   = !ld_present && (ld_rows != '0);
		ld_col_end = (DIM_W'(ld_c) == ld_cols - DIM_W'(1));
		ld_last    = ld_col_end && (DIM_W'(ld_r) == ld_rows - DIM_W'(1));

		lf_rows      = first_element ? rows : left_rows_q;
		lf_cols      = first_element ? cols : left_cols_q;
		lf_row       = first_element ? '0 : lrow_q;
		lf_pos       = first_element ? '0 : lpos_q;
		lf_start_err = first_element &&
			(!right_present_q || !dims_ok || cols != right_rows_q);
		lf_active    = !lf_start_err && (first_element || !left_skip_q) &&
			(lf_cols != '0) && (lf_row != lf_rows);
		lf_row_end   = (DIM_W'(lf_pos) == lf_cols - DIM_W'(1));
	end

	assign wr.en   = in_fire && (command == CMD_LOAD) && ld_write;
	assign wr.row  = DIM_W'(ld_r);
	assign wr.col  = DIM_W'(ld_c);
	assign wr.data = value;

	assign ctl.clr     = (state_q == S_FEED) && (feed_idx_q == '0);
	assign ctl.capture = (state_q == S_WAIT) && !feed_q.valid && !chain_busy;
	assign ctl.shift   = (state_q == S_DRAIN) && out_fire;

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LEFT && lf_active) begin
			lbuf_q[lf_pos] <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			right_rows_q    <= '0;
			right_cols_q    <= '0;
			right_present_q <= 1'b0;
			ld_r_q          <= '0;
			ld_c_q          <= '0;
			left_rows_q     <= '0;
			left_cols_q     <= '0;
			lrow_q          <= '0;
			lpos_q          <= '0;
			left_skip_q     <= 1'b0;
			scale_q         <= '0;
			pass_scale_q    <= 1'b0;
			final_row_q     <= 1'b0;
			feed_idx_q      <= '0;
			orow_q          <= '0;
			ocol_q          <= '0;
			orows_q         <= '0;
			ocols_q         <= '0;
			status_q        <= ST_OK;
			feed_q          <= '0;
		end else begin
			feed_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (command)
							CMD_LOAD: begin
								right_rows_q    <= ld_rows;
								right_cols_q    <= ld_cols;
								ld_r_q          <= ld_r;
								ld_c_q          <= ld_c;
								right_present_q <= ld_present;
								if (ld_write) begin
									if (ld_col_end) begin
										ld_c_q <= '0;
										ld_r_q <= ld_r + IDX_W'(1);
									end else begin
										ld_c_q <= ld_c + IDX_W'(1);
									end
									if (ld_last) begin
										right_present_q <= 1'b1;
									end
								end
							end
							CMD_LEFT: begin
								if (first_element) begin
									lrow_q      <= '0;
									lpos_q      <= '0;
									left_skip_q <= lf_start_err;
									left_rows_q <= lf_start_err ? '0 : rows;
									left_cols_q <= lf_start_err ? '0 : cols;
								end
								if (lf_start_err) begin
									status_q <= right_present_q ? ST_MISMATCH : ST_MISSING;
									orow_q   <= '0;
									ocol_q   <= '0;
									orows_q  <= '0;
									ocols_q  <= '0;
									state_q  <= S_ERR;
								end else if (lf_active) begin
									if (lf_row_end) begin
										lpos_q <= '0;
										lrow_q <= lf_row + DIM_W'(1);
										if (!right_present_q || right_rows_q != lf_cols) begin
											// held matrix changed under the stream: drop the rest
											left_skip_q <= 1'b1;
											status_q    <= right_present_q ? ST_MISMATCH
												: ST_MISSING;
											orow_q      <= '0;
											ocol_q      <= '0;
											orows_q     <= '0;
											ocols_q     <= '0;
											state_q     <= S_ERR;
										end else begin
											pass_scale_q <= 1'b0;
											orow_q       <= lf_row[IDX_W-1:0];
											ocol_q       <= '0;
											orows_q      <= lf_rows;
											ocols_q      <= right_cols_q;
											final_row_q  <= (lf_row + DIM_W'(1) == lf_rows);
											status_q     <= ST_OK;
											feed_idx_q   <= '0;
											state_q      <= S_FEED;
										end
									end else begin
										lpos_q <= lf_pos + IDX_W'(1);
									end
								end
							end
							CMD_SCALE: begin
								if (!right_present_q) begin
									status_q <= ST_MISSING;
									orow_q   <= '0;
									ocol_q   <= '0;
									orows_q  <= '0;
									ocols_q  <= '0;
									state_q  <= S_ERR;
								end else begin
									pass_scale_q <= 1'b1;
									scale_q      <= value;
									orow_q       <= '0;
									ocol_q       <= '0;
									orows_q      <= right_rows_q;
									ocols_q      <= right_cols_q;
									final_row_q  <= (right_rows_q == DIM_W'(1));
									status_q     <= ST_OK;
									feed_idx_q   <= '0;
									state_q      <= S_FEED;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FEED: begin
					feed_q.valid <= 1'b1;
					feed_q.a     <= pass_scale_q ? scale_q : lbuf_q[feed_idx_q];
					feed_q.n     <= DIM_W'(pass_scale_q ? orow_q : feed_idx_q);
					feed_idx_q   <= feed_idx_q + IDX_W'(1);
					if (pass_scale_q || DIM_W'(feed_idx_q) == left_cols_q - DIM_W'(1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (ctl.capture) begin
						ocol_q  <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (out_fire) begin
						if (DIM_W'(ocol_q) == ocols_q - DIM_W'(1)) begin
							if (pass_scale_q && !final_row_q) begin
								// advance to the next row of the held matrix
								orow_q      <= orow_q + IDX_W'(1);
								final_row_q <= (DIM_W'(orow_q) + DIM_W'(2) == right_rows_q);
								feed_idx_q  <= '0;
								state_q     <= S_FEED;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							ocol_q <= ocol_q + IDX_W'(1);
						end
					end
				end
				S_ERR: begin
					if (out_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign link[0]       = feed_q;
	assign res[MAX_DIM]  = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mms_cell #(
			.MAX_DIM (MAX_DIM),
			.IDX     (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr       (wr),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.res_in   (res[g+1]),
			.res_out  (res[g]),
			.busy     (busy[g])
		);
	end

	assign chain_busy = (|busy) | link[MAX_DIM].valid;

	assign out_value = (status_q == ST_OK) ? res[0] : '0;
	assign out_row   = 3'(orow_q);
	assign out_col   = 3'(ocol_q);
	assign out_rows  = orows_q;
	assign out_cols  = ocols_q;
	assign status    = status_q;
	assign last      = (status_q != ST_OK) ||
		(final_row_q && DIM_W'(ocol_q) == ocols_q - DIM_W'(1));

endmodule

@@ rtl/mms_sva.sv @@
module mms_sva (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [mms_pkg::VAL_W-1:0]  out_value,
	input logic [2:0]                        out_col,
	input logic [mms_pkg::DIM_W-1:0]         out_rows,
	input logic [mms_pkg::DIM_W-1:0]         out_cols,
	input logic [mms_pkg::STAT_W-1:0]        status,
	input logic                              last
);
	import mms_pkg::*;

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(status)
			&& $stable(last))
		else $error("result changed while stalled");

	// no new request taken while a result is pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while a result is pending");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && out_value == '0 && out_rows == '0
			&& out_cols == '0)
		else $error("error result with nonzero payload");

	a_ok_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> out_rows != '0 && out_cols != '0
			&& {1'b0, out_col} < out_cols)
		else $error("result column outside the result matrix");

endmodule

bind matrix_multiply_stream mms_sva u_mms_sva (.*);
